// ----- rtl/rsdz_pkg.sv -----
`default_nettype none
package rsdz_pkg;

	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int AXIS_W            = 16;
	localparam int SQ_W              = 32;
	localparam int SQRT_STEPS        = 16;
	localparam int Q_BITS            = 16;
	localparam int CFG_IDX_W         = 2;

	localparam logic [AXIS_W-1:0] DEAD_ZONE_RST  = 16'd8000;
	localparam logic [AXIS_W-1:0] FULL_SCALE_RST = 16'd30000;

	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;

	typedef struct packed {
		logic [AXIS_W-1:0] ax;
		logic [AXIS_W-1:0] ay;
		logic              nx;
		logic              ny;
	} axis_t;

	typedef struct packed {
		logic nx;
		logic ny;
		logic kill;
		logic dead;
	} flags_t;

endpackage
`default_nettype wire

// ----- rtl/radial_stick_dead_zone_unit.sv -----
// Radial dead zone for one stick sample per clock. A sample is taken whenever
// start is high (busy stays low), and its result appears later with done high
// for one cycle; the receiver cannot stall, so results must be taken as they
// come. Most of the latency lies in the 16-stage square root and the 16-stage
// restoring divider, one result bit per stage. dead_zone and full_scale may
// only be written while no sample is in flight.
`default_nettype none
module radial_stick_dead_zone_unit import rsdz_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic signed [15:0]    in_x,
	input  wire logic signed [15:0]    in_y,
	output logic                       done,
	output logic signed [15:0]         out_x,
	output logic signed [15:0]         out_y,
	output logic                       in_dead,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]           cfg_data
);

	localparam int NW = SQ_W + OUT_FRAC_BITS;

	logic [AXIS_W-1:0] dead_zone_q, full_scale_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q  <= DEAD_ZONE_RST;
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DEAD_ZONE)  dead_zone_q  <= cfg_data;
			if (cfg_index == REG_FULL_SCALE) full_scale_q <= cfg_data;
		end
	end

	logic        valid_s1, valid_s2, valid_s3;
	axis_t       ax_s1, ax_s2, ax_s3;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1.nx <= in_x[15];
		ax_s1.ny <= in_y[15];
		ax_s1.ax <= in_x[15] ? 16'(-in_x) : 16'(in_x);
		ax_s1.ay <= in_y[15] ? 16'(-in_y) : 16'(in_y);
		ax_s2    <= ax_s1;
		sqx_s2   <= ax_s1.ax * ax_s1.ax;
		sqy_s2   <= ax_s1.ay * ax_s1.ay;
		ax_s3    <= ax_s2;
		sum_s3   <= sqx_s2 + sqy_s2;
	end

	logic              sq_valid;
	logic [AXIS_W-1:0] len;
	axis_t             sq_tag;

	rsdz_isqrt #(.TAG_W($bits(axis_t))) u_isqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(valid_s3), .in_v(sum_s3), .in_tag(ax_s3),
		.out_valid(sq_valid), .root(len), .out_tag(sq_tag)
	);

	logic              full_mode;
	logic              valid_s4, valid_s5;
	axis_t             ax_s4;
	flags_t            fl_s4, fl_s5;
	logic [AXIS_W-1:0] num_s4, dm_s4, len_s4;
	logic [SQ_W-1:0]   mx_s5, my_s5, den_s5;

	assign full_mode = (full_scale_q <= dead_zone_q) || (len >= full_scale_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= sq_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		ax_s4      <= sq_tag;
		len_s4     <= len;
		fl_s4.nx   <= sq_tag.nx;
		fl_s4.ny   <= sq_tag.ny;
		fl_s4.dead <= len < dead_zone_q;
		fl_s4.kill <= (len < dead_zone_q) || (len == '0);
		num_s4     <= full_mode ? 16'd1 : len - dead_zone_q;
		dm_s4      <= full_mode ? 16'd1 : full_scale_q - dead_zone_q;
		fl_s5      <= fl_s4;
		mx_s5      <= ax_s4.ax * num_s4;
		my_s5      <= ax_s4.ay * num_s4;
		den_s5     <= dm_s4 * len_s4;
	end

	logic              dv_valid, ovf_x, ovf_y;
	logic [Q_BITS-1:0] qx, qy;
	flags_t            dv_fl;

	rsdz_div #(.NW(NW), .TAG_W($bits(flags_t))) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(valid_s5),
		.n0(NW'(mx_s5) << OUT_FRAC_BITS), .n1(NW'(my_s5) << OUT_FRAC_BITS),
		.d(den_s5), .in_tag(fl_s5),
		.out_valid(dv_valid), .q0(qx), .q1(qy), .ovf0(ovf_x), .ovf1(ovf_y),
		.out_tag(dv_fl)
	);

	function automatic logic [15:0] sat_sign(input logic [Q_BITS-1:0] q, input logic ovf,
			input logic neg);
		logic [Q_BITS-1:0] m;
		if (neg) begin
			m = (ovf || q > 16'h8000) ? 16'h8000 : q;
			return 16'(-m);
		end
		return (ovf || q[15]) ? 16'h7FFF : q;
	endfunction

	logic              valid_s6, dead_s6;
	logic [15:0]       ox_s6, oy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s6 <= 1'b0;
		else         valid_s6 <= dv_valid;
	end

	always_ff @(posedge clk) begin
		dead_s6 <= dv_fl.dead;
		ox_s6   <= dv_fl.kill ? '0 : sat_sign(qx, ovf_x, dv_fl.nx);
		oy_s6   <= dv_fl.kill ? '0 : sat_sign(qy, ovf_y, dv_fl.ny);
	end

	assign done    = valid_s6;
	assign out_x   = ox_s6;
	assign out_y   = oy_s6;
	assign in_dead = dead_s6;

endmodule
`default_nettype wire

// ----- rtl/rsdz_isqrt.sv -----
`default_nettype none
module rsdz_isqrt import rsdz_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [SQ_W-1:0]   in_v,
	input  wire logic [TAG_W-1:0]  in_tag,
	output logic                   out_valid,
	output logic [AXIS_W-1:0]      root,
	output logic [TAG_W-1:0]       out_tag
);

	logic [SQ_W-1:0]  v_s    [0:SQRT_STEPS-1];
	logic [SQ_W-1:0]  root_s [0:SQRT_STEPS];
	logic [TAG_W-1:0] tag_s  [0:SQRT_STEPS];
	logic [SQRT_STEPS:0] valid_s;

	assign v_s[0]     = in_v;
	assign root_s[0]  = '0;
	assign tag_s[0]   = in_tag;
	assign valid_s[0] = in_valid;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (SQ_W - 2 - 2*k);
		logic [SQ_W:0] trial;
		logic          take;

		assign trial = {1'b0, root_s[k]} + BIT;
		assign take  = {1'b0, v_s[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k+1] <= 1'b0;
			else         valid_s[k+1] <= valid_s[k];
		end

		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_s[k];
			if (take) root_s[k+1] <= SQ_W'((root_s[k] >> 1) + BIT);
			else      root_s[k+1] <= root_s[k] >> 1;
		end

		if (k < SQRT_STEPS-1) begin : g_rem
			always_ff @(posedge clk) begin
				if (take) v_s[k+1] <= SQ_W'({1'b0, v_s[k]} - trial);
				else      v_s[k+1] <= v_s[k];
			end
		end
	end

	assign out_valid = valid_s[SQRT_STEPS];
	assign root      = root_s[SQRT_STEPS][AXIS_W-1:0];
	assign out_tag   = tag_s[SQRT_STEPS];

endmodule
`default_nettype wire

// ----- rtl/rsdz_div.sv -----
`default_nettype none
module rsdz_div import rsdz_pkg::*; #(
	parameter int NW    = 46,
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [NW-1:0]    n0,
	input  wire logic [NW-1:0]    n1,
	input  wire logic [SQ_W-1:0]  d,
	input  wire logic [TAG_W-1:0] in_tag,
	output logic                  out_valid,
	output logic [Q_BITS-1:0]     q0,
	output logic [Q_BITS-1:0]     q1,
	output logic                  ovf0,
	output logic                  ovf1,
	output logic [TAG_W-1:0]      out_tag
);

	localparam int WW = NW + SQ_W + Q_BITS;

	logic [WW-1:0]     r0_s  [0:Q_BITS-1];
	logic [WW-1:0]     r1_s  [0:Q_BITS-1];
	logic [SQ_W-1:0]   d_s   [0:Q_BITS-1];
	logic [Q_BITS-1:0] q0_s  [0:Q_BITS];
	logic [Q_BITS-1:0] q1_s  [0:Q_BITS];
	logic              o0_s  [0:Q_BITS];
	logic              o1_s  [0:Q_BITS];
	logic [TAG_W-1:0]  tag_s [0:Q_BITS];
	logic [Q_BITS:0]   valid_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else         valid_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		r0_s[0]  <= WW'(n0);
		r1_s[0]  <= WW'(n1);
		d_s[0]   <= d;
		q0_s[0]  <= '0;
		q1_s[0]  <= '0;
		o0_s[0]  <= WW'(n0) >= (WW'(d) << Q_BITS);
		o1_s[0]  <= WW'(n1) >= (WW'(d) << Q_BITS);
		tag_s[0] <= in_tag;
	end

	for (genvar i = 0; i < Q_BITS; i++) begin : g_step
		logic [WW-1:0] dsh;
		logic          t0, t1;

		assign dsh = WW'(d_s[i]) << (Q_BITS - 1 - i);
		assign t0  = r0_s[i] >= dsh;
		assign t1  = r1_s[i] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[i+1] <= 1'b0;
			else         valid_s[i+1] <= valid_s[i];
		end

		always_ff @(posedge clk) begin
			q0_s[i+1]  <= {q0_s[i][Q_BITS-2:0], t0};
			q1_s[i+1]  <= {q1_s[i][Q_BITS-2:0], t1};
			o0_s[i+1]  <= o0_s[i];
			o1_s[i+1]  <= o1_s[i];
			tag_s[i+1] <= tag_s[i];
		end

		if (i < Q_BITS-1) begin : g_rem
			always_ff @(posedge clk) begin
				r0_s[i+1] <= t0 ? r0_s[i] - dsh : r0_s[i];
				r1_s[i+1] <= t1 ? r1_s[i] - dsh : r1_s[i];
				d_s[i+1]  <= d_s[i];
			end
		end
	end

	assign out_valid = valid_s[Q_BITS];
	assign q0        = q0_s[Q_BITS];
	assign q1        = q1_s[Q_BITS];
	assign ovf0      = o0_s[Q_BITS];
	assign ovf1      = o1_s[Q_BITS];
	assign out_tag   = tag_s[Q_BITS];

endmodule
`default_nettype wire
